FILE: hdl/nlss_pkg.sv
// Shared types, codes and the per-marker arithmetic step list for the nearest line search.
`timescale 1ns / 1ps
`default_nettype none
package nlss_pkg;

  localparam int DEF_MAX_GROUPS  = 8;
  localparam int DEF_MAX_MARKERS = 64;
  localparam int DEF_COORD_BITS  = 32;

  // Fixed field widths of the channel words
  localparam int OP_W       = 3;
  localparam int IDX_W      = 8;
  localparam int ENDS_W     = 2;
  localparam int IN_COORD_W = 32;
  localparam int STATUS_W   = 2;
  localparam int FGRP_W     = 3;
  localparam int FMRK_W     = 6;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE   = 3'd0,
    OP_CLEAR   = 3'd1,
    OP_NEAREST = 3'd2,
    OP_PREV    = 3'd3,
    OP_NEXT    = 3'd4,
    OP_LEFT    = 3'd5,
    OP_RIGHT   = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_NONE    = 2'd1,
    ST_MISSING = 2'd2,
    ST_EMPTY   = 2'd3
  } status_e;

  localparam logic [ENDS_W-1:0] ENDS_BOTH = 2'b11;

  // Operand sources of the multiply-accumulate unit
  typedef enum logic [2:0] {
    A_ABX, A_ABY, A_ABZ, A_CX, A_CY, A_CZ, A_NUM, A_BEST_NUM
  } asrc_e;

  typedef enum logic [3:0] {
    B_APX, B_APY, B_APZ, B_ABX, B_ABY, B_ABZ, B_CX, B_CY, B_CZ, B_LEN, B_BEST_LEN
  } bsrc_e;

  // Where the accumulator goes when a step finishes
  typedef enum logic [2:0] {
    D_NONE, D_CX, D_CY, D_CZ, D_NUM, D_LEN, D_CMP
  } dst_e;

  typedef struct packed {
    asrc_e a;
    bsrc_e b;
    logic  sub;
    logic  clr;
    dst_e  dst;
  } step_t;

  typedef struct packed {
    logic start;
    logic clr;
    logic sub;
  } mac_cmd_t;

  localparam int STEP_W = 4;

  // Per marker: three cross products, |AB x AP|^2, |AB|^2, then the
  // cross-multiplied compare against the best marker so far.
  function automatic step_t step_of(input logic [STEP_W-1:0] k);
    step_t s;
    unique case (k)
      4'd0:    s = '{A_ABY, B_APZ, 1'b0, 1'b1, D_NONE};
      4'd1:    s = '{A_ABZ, B_APY, 1'b1, 1'b0, D_CX};
      4'd2:    s = '{A_ABZ, B_APX, 1'b0, 1'b1, D_NONE};
      4'd3:    s = '{A_ABX, B_APZ, 1'b1, 1'b0, D_CY};
      4'd4:    s = '{A_ABX, B_APY, 1'b0, 1'b1, D_NONE};
      4'd5:    s = '{A_ABY, B_APX, 1'b1, 1'b0, D_CZ};
      4'd6:    s = '{A_CX, B_CX, 1'b0, 1'b1, D_NONE};
      4'd7:    s = '{A_CY, B_CY, 1'b0, 1'b0, D_NONE};
      4'd8:    s = '{A_CZ, B_CZ, 1'b0, 1'b0, D_NUM};
      4'd9:    s = '{A_ABX, B_ABX, 1'b0, 1'b1, D_NONE};
      4'd10:   s = '{A_ABY, B_ABY, 1'b0, 1'b0, D_NONE};
      4'd11:   s = '{A_ABZ, B_ABZ, 1'b0, 1'b0, D_LEN};
      4'd12:   s = '{A_NUM, B_BEST_LEN, 1'b0, 1'b1, D_NONE};
      4'd13:   s = '{A_BEST_NUM, B_LEN, 1'b1, 1'b0, D_CMP};
      default: s = '{A_ABX, B_ABX, 1'b0, 1'b1, D_NONE};
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/nlss_if.sv
// Valid/ready channel interfaces for command words and result words.
`timescale 1ns / 1ps
`default_nettype none
interface nlss_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [nlss_pkg::OP_W-1:0]             operation;
  logic [nlss_pkg::IDX_W-1:0]            group_index;
  logic [nlss_pkg::IDX_W-1:0]            marker_index;
  logic [nlss_pkg::ENDS_W-1:0]           ends_present;
  logic signed [nlss_pkg::IN_COORD_W-1:0] first_x;
  logic signed [nlss_pkg::IN_COORD_W-1:0] first_y;
  logic signed [nlss_pkg::IN_COORD_W-1:0] first_z;
  logic signed [nlss_pkg::IN_COORD_W-1:0] second_x;
  logic signed [nlss_pkg::IN_COORD_W-1:0] second_y;
  logic signed [nlss_pkg::IN_COORD_W-1:0] second_z;

  modport source (
    output valid, operation, group_index, marker_index, ends_present,
           first_x, first_y, first_z, second_x, second_y, second_z,
    input  ready
  );
  modport sink (
    input  valid, operation, group_index, marker_index, ends_present,
           first_x, first_y, first_z, second_x, second_y, second_z,
    output ready
  );
endinterface

interface nlss_out_if;
  logic                          valid;
  logic                          ready;
  logic [nlss_pkg::STATUS_W-1:0] status;
  logic [nlss_pkg::FGRP_W-1:0]   found_group;
  logic [nlss_pkg::FMRK_W-1:0]   found_marker;

  modport source (output valid, status, found_group, found_marker, input ready);
  modport sink (input valid, status, found_group, found_marker, output ready);
endinterface
`default_nettype wire

FILE: hdl/nearest_line_segment_search_core.sv
// Top level: marker table control, neighbour lookups and nearest line search.
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | Word contents
// --------+-----+-------------------------------------------------------------
// in_i    | in  | operation, group/marker index, ends_present, first_*, second_*
// out_o   | out | status, found_group, found_marker (one word per command word)
//
// Write, clear, neighbour and unused commands are accepted, then handed off to
// the output register. A nearest search reads each marker from the table
// through its registered read port and runs it through one bit-serial
// multiply-accumulate unit: 14 steps per usable marker, 12 steps for the
// first one.
// Reset clears group sizes, group count and the control state; the table
// memory itself is not cleared. The output register holds a word while out_o
// stalls; a new command word is taken once the previous result is handed off.
module nearest_line_segment_search_core #(
  parameter int MAX_GROUPS  = nlss_pkg::DEF_MAX_GROUPS,
  parameter int MAX_MARKERS = nlss_pkg::DEF_MAX_MARKERS,
  parameter int COORD_BITS  = nlss_pkg::DEF_COORD_BITS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  nlss_in_if.sink        in_i,
  nlss_out_if.source     out_o
);
  import nlss_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int GIW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int GCW    = $clog2(MAX_GROUPS + 1);
  localparam int SW     = $clog2(MAX_MARKERS + 1);
  localparam int DEPTH  = MAX_GROUPS * MAX_MARKERS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ENT_W  = 6 * C + ENDS_W;
  localparam int DW     = C + 1;        // coordinate difference
  localparam int XW     = 2 * C + 3;    // cross product, squared length
  localparam int NW     = 4 * C + 5;    // squared cross magnitude
  localparam int AW     = 6 * C + 7;    // compare accumulator
  localparam int CMPW   = ((SW > IDX_W) ? SW : IDX_W) + 1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DONE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_GO   = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [SW-1:0]       sizes_q [MAX_GROUPS];
  logic [SW-1:0]       sizes_d [MAX_GROUPS];
  logic [GCW-1:0]      total_q, total_d;
  logic [GCW-1:0]      g_q, g_d;
  logic [SW-1:0]       m_q, m_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                have_q, have_d;
  logic                out_valid_q, out_valid_d;
  status_e             out_status_q, out_status_d;
  logic [FGRP_W-1:0]   out_grp_q, out_grp_d;
  logic [FMRK_W-1:0]   out_mrk_q, out_mrk_d;
  status_e             res_status_q, res_status_d;
  logic [FGRP_W-1:0]   res_grp_q, res_grp_d;
  logic [FMRK_W-1:0]   res_mrk_q, res_mrk_d;
  logic [FGRP_W-1:0]   best_g_q, best_g_d;
  logic [FMRK_W-1:0]   best_m_q, best_m_d;

  logic signed [C-1:0]  qx_q, qx_d, qy_q, qy_d, qz_q, qz_d;
  logic signed [DW-1:0] abx_q, abx_d, aby_q, aby_d, abz_q, abz_d;
  logic signed [DW-1:0] apx_q, apx_d, apy_q, apy_d, apz_q, apz_d;
  logic signed [XW-1:0] cx_q, cx_d, cy_q, cy_d, cz_q, cz_d;
  logic signed [XW-1:0] len_q, len_d, best_len_q, best_len_d;
  logic signed [NW-1:0] num_q, num_d, best_num_q, best_num_d;

  // table ports
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [ENT_W-1:0]  wr_data, rd_data;

  // multiply-accumulate unit
  mac_cmd_t             mac_cmd;
  logic signed [NW-1:0] mac_a;
  logic signed [XW-1:0] mac_b;
  logic                 mac_done;
  logic signed [AW-1:0] mac_acc;
  step_t                st;

  // entry fields as read back
  logic signed [C-1:0]  sx_w, sy_w, sz_w, ex_w, ey_w, ez_w;
  logic [ENDS_W-1:0]    flags_w;
  logic signed [DW-1:0] abx_w, aby_w, abz_w;

  // command decode
  logic [GIW-1:0]  in_gi;
  logic [CMPW-1:0] in_g_c, in_m_c, in_size_c, in_total_c;
  logic            wr_ok, in_table;
  logic            in_ready;

  assign in_gi      = in_i.group_index[GIW-1:0];
  assign in_g_c     = CMPW'(in_i.group_index);
  assign in_m_c     = CMPW'(in_i.marker_index);
  assign in_total_c = CMPW'(total_q);
  assign in_size_c  = CMPW'(sizes_q[in_gi]);
  assign wr_ok      = (in_g_c < CMPW'(MAX_GROUPS)) && (in_m_c < CMPW'(MAX_MARKERS));
  // group count never exceeds MAX_GROUPS, so this also bounds the index
  assign in_table   = (in_g_c < in_total_c) && (in_m_c < in_size_c);

  assign wr_addr = ADDR_W'(int'(in_i.group_index) * MAX_MARKERS + int'(in_i.marker_index));
  assign wr_data = {in_i.ends_present,
                    C'(in_i.second_z), C'(in_i.second_y), C'(in_i.second_x),
                    C'(in_i.first_z), C'(in_i.first_y), C'(in_i.first_x)};
  assign rd_addr = ADDR_W'(int'(g_q) * MAX_MARKERS + int'(m_q));

  assign sx_w    = rd_data[C-1:0];
  assign sy_w    = rd_data[2*C-1:C];
  assign sz_w    = rd_data[3*C-1:2*C];
  assign ex_w    = rd_data[4*C-1:3*C];
  assign ey_w    = rd_data[5*C-1:4*C];
  assign ez_w    = rd_data[6*C-1:5*C];
  assign flags_w = rd_data[6*C+ENDS_W-1:6*C];
  assign abx_w   = DW'(ex_w) - DW'(sx_w);
  assign aby_w   = DW'(ey_w) - DW'(sy_w);
  assign abz_w   = DW'(ez_w) - DW'(sz_w);

  assign st = step_of(step_q);

  // operand selection for the current step
  always_comb begin
    unique case (st.a)
      A_ABX:      mac_a = NW'(abx_q);
      A_ABY:      mac_a = NW'(aby_q);
      A_ABZ:      mac_a = NW'(abz_q);
      A_CX:       mac_a = NW'(cx_q);
      A_CY:       mac_a = NW'(cy_q);
      A_CZ:       mac_a = NW'(cz_q);
      A_NUM:      mac_a = num_q;
      A_BEST_NUM: mac_a = best_num_q;
    endcase
    unique case (st.b)
      B_APX:      mac_b = XW'(apx_q);
      B_APY:      mac_b = XW'(apy_q);
      B_APZ:      mac_b = XW'(apz_q);
      B_ABX:      mac_b = XW'(abx_q);
      B_ABY:      mac_b = XW'(aby_q);
      B_ABZ:      mac_b = XW'(abz_q);
      B_CX:       mac_b = cx_q;
      B_CY:       mac_b = cy_q;
      B_CZ:       mac_b = cz_q;
      B_LEN:      mac_b = len_q;
      B_BEST_LEN: mac_b = best_len_q;
      default:    mac_b = '0;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    sizes_d      = sizes_q;
    total_d      = total_q;
    g_d          = g_q;
    m_d          = m_q;
    step_d       = step_q;
    have_d       = have_q;
    out_valid_d  = out_valid_q & ~out_o.ready;
    out_status_d = out_status_q;
    out_grp_d    = out_grp_q;
    out_mrk_d    = out_mrk_q;
    res_status_d = res_status_q;
    res_grp_d    = res_grp_q;
    res_mrk_d    = res_mrk_q;
    best_g_d     = best_g_q;
    best_m_d     = best_m_q;
    best_num_d   = best_num_q;
    best_len_d   = best_len_q;
    qx_d = qx_q;  qy_d = qy_q;  qz_d = qz_q;
    abx_d = abx_q;  aby_d = aby_q;  abz_d = abz_q;
    apx_d = apx_q;  apy_d = apy_q;  apz_d = apz_q;
    cx_d = cx_q;  cy_d = cy_q;  cz_d = cz_q;
    len_d = len_q;
    num_d = num_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    in_ready = 1'b0;
    mac_cmd  = '0;

    unique case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          state_d      = S_DONE;
          res_status_d = ST_NONE;
          res_grp_d    = '0;
          res_mrk_d    = '0;
          unique case (in_i.operation)
            OP_WRITE: begin
              if (wr_ok) begin
                wr_en = 1'b1;
                if (sizes_q[in_gi] < SW'(in_i.marker_index) + SW'(1)) begin
                  sizes_d[in_gi] = SW'(in_i.marker_index) + SW'(1);
                end
                if (total_q < GCW'(in_i.group_index) + GCW'(1)) begin
                  total_d = GCW'(in_i.group_index) + GCW'(1);
                end
                res_status_d = ST_OK;
                res_grp_d    = FGRP_W'(in_i.group_index);
                res_mrk_d    = FMRK_W'(in_i.marker_index);
              end
            end
            OP_CLEAR: begin
              sizes_d      = '{default: '0};
              total_d      = '0;
              res_status_d = ST_OK;
            end
            OP_NEAREST: begin
              qx_d    = C'(in_i.first_x);
              qy_d    = C'(in_i.first_y);
              qz_d    = C'(in_i.first_z);
              g_d     = '0;
              m_d     = '0;
              have_d  = 1'b0;
              state_d = S_SCAN;
            end
            OP_PREV: begin
              if (in_table && (in_m_c != '0)) begin
                res_status_d = ST_OK;
                res_grp_d    = FGRP_W'(in_i.group_index);
                res_mrk_d    = FMRK_W'(in_i.marker_index - IDX_W'(1));
              end
            end
            OP_NEXT: begin
              if (in_table && (in_m_c + CMPW'(1) < in_size_c)) begin
                res_status_d = ST_OK;
                res_grp_d    = FGRP_W'(in_i.group_index);
                res_mrk_d    = FMRK_W'(in_i.marker_index + IDX_W'(1));
              end
            end
            OP_LEFT: begin
              if (in_table && (in_g_c != '0)) begin
                res_status_d = ST_OK;
                res_grp_d    = FGRP_W'(in_i.group_index - IDX_W'(1));
                res_mrk_d    = FMRK_W'(in_i.marker_index);
              end
            end
            OP_RIGHT: begin
              if (in_table && (in_g_c + CMPW'(1) < in_total_c)) begin
                res_status_d = ST_OK;
                res_grp_d    = FGRP_W'(in_i.group_index + IDX_W'(1));
                res_mrk_d    = FMRK_W'(in_i.marker_index);
              end
            end
            default: ;
          endcase
        end
      end

      S_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_grp_d    = res_grp_q;
          out_mrk_d    = res_mrk_q;
          state_d      = S_IDLE;
        end
      end

      S_SCAN: begin
        if (g_q >= total_q) begin
          // walked off the last group
          state_d = S_DONE;
          if (have_q) begin
            res_status_d = ST_OK;
            res_grp_d    = best_g_q;
            res_mrk_d    = best_m_q;
          end else begin
            res_status_d = ST_EMPTY;
            res_grp_d    = '0;
            res_mrk_d    = '0;
          end
        end else if (m_q >= sizes_q[g_q[GIW-1:0]]) begin
          g_d = g_q + GCW'(1);
          m_d = '0;
        end else begin
          rd_en   = 1'b1;
          state_d = S_LOAD;
        end
      end

      S_LOAD: begin
        if (flags_w != ENDS_BOTH) begin
          res_status_d = ST_MISSING;
          res_grp_d    = FGRP_W'(g_q);
          res_mrk_d    = FMRK_W'(m_q);
          state_d      = S_DONE;
        end else if ((abx_w == '0) && (aby_w == '0) && (abz_w == '0)) begin
          // zero-length marker has no line
          m_d     = m_q + SW'(1);
          state_d = S_SCAN;
        end else begin
          abx_d   = abx_w;
          aby_d   = aby_w;
          abz_d   = abz_w;
          apx_d   = DW'(qx_q) - DW'(sx_w);
          apy_d   = DW'(qy_q) - DW'(sy_w);
          apz_d   = DW'(qz_q) - DW'(sz_w);
          step_d  = '0;
          state_d = S_GO;
        end
      end

      S_GO: begin
        mac_cmd.start = 1'b1;
        mac_cmd.clr   = st.clr;
        mac_cmd.sub   = st.sub;
        state_d       = S_WAIT;
      end

      S_WAIT: begin
        if (mac_done) begin
          unique case (st.dst)
            D_CX:  cx_d  = XW'(mac_acc);
            D_CY:  cy_d  = XW'(mac_acc);
            D_CZ:  cz_d  = XW'(mac_acc);
            D_NUM: num_d = NW'(mac_acc);
            D_LEN: begin
              len_d = XW'(mac_acc);
              if (!have_q) begin
                // first usable marker wins outright
                have_d     = 1'b1;
                best_num_d = num_q;
                best_len_d = XW'(mac_acc);
                best_g_d   = FGRP_W'(g_q);
                best_m_d   = FMRK_W'(m_q);
              end
            end
            D_CMP: begin
              // strictly nearer only; a tie keeps the earlier marker
              if (mac_acc[AW-1]) begin
                best_num_d = num_q;
                best_len_d = len_q;
                best_g_d   = FGRP_W'(g_q);
                best_m_d   = FMRK_W'(m_q);
              end
            end
            default: ;
          endcase
          if (((st.dst == D_LEN) && !have_q) || (st.dst == D_CMP)) begin
            m_d     = m_q + SW'(1);
            state_d = S_SCAN;
          end else begin
            step_d  = step_q + STEP_W'(1);
            state_d = S_GO;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sizes_q     <= '{default: '0};
      total_q     <= '0;
      g_q         <= '0;
      m_q         <= '0;
      step_q      <= '0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sizes_q     <= sizes_d;
      total_q     <= total_d;
      g_q         <= g_d;
      m_q         <= m_d;
      step_q      <= step_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_grp_q    <= out_grp_d;
    out_mrk_q    <= out_mrk_d;
    res_status_q <= res_status_d;
    res_grp_q    <= res_grp_d;
    res_mrk_q    <= res_mrk_d;
    best_g_q     <= best_g_d;
    best_m_q     <= best_m_d;
    best_num_q   <= best_num_d;
    best_len_q   <= best_len_d;
    qx_q  <= qx_d;   qy_q  <= qy_d;   qz_q  <= qz_d;
    abx_q <= abx_d;  aby_q <= aby_d;  abz_q <= abz_d;
    apx_q <= apx_d;  apy_q <= apy_d;  apz_q <= apz_d;
    cx_q  <= cx_d;   cy_q  <= cy_d;   cz_q  <= cz_d;
    len_q <= len_d;
    num_q <= num_d;
  end

  nlss_table #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W),
    .DATA_W (ENT_W)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  nlss_mac #(
    .NW (NW),
    .XW (XW),
    .AW (AW)
  ) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mac_cmd),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .done_o (mac_done),
    .acc_o  (mac_acc)
  );

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.found_group  = out_grp_q;
  assign out_o.found_marker = out_mrk_q;

endmodule
`default_nettype wire

FILE: hdl/nlss_table.sv
// Marker table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module nlss_table #(
  parameter int DEPTH  = nlss_pkg::DEF_MAX_GROUPS * nlss_pkg::DEF_MAX_MARKERS,
  parameter int ADDR_W = $clog2(DEPTH),
  parameter int DATA_W = 6 * nlss_pkg::DEF_COORD_BITS + nlss_pkg::ENDS_W
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [DATA_W-1:0] wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [DATA_W-1:0] rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

FILE: hdl/nlss_mac.sv
// Bit-serial signed multiply-accumulate unit, one multiplier bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nlss_mac #(
  parameter int NW = 4 * nlss_pkg::DEF_COORD_BITS + 5,
  parameter int XW = 2 * nlss_pkg::DEF_COORD_BITS + 3,
  parameter int AW = 6 * nlss_pkg::DEF_COORD_BITS + 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  nlss_pkg::mac_cmd_t    cmd_i,
  input  logic signed [NW-1:0]  a_i,
  input  logic signed [XW-1:0]  b_i,
  output logic                  done_o,
  output logic signed [AW-1:0]  acc_o
);

  localparam int CW = $clog2(XW);
  localparam logic [CW-1:0] CNT_LAST = CW'(XW - 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic                 sub_q, sub_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic signed [AW-1:0] a_q, a_d;
  logic [XW-1:0]        b_q, b_d;
  logic signed [AW-1:0] acc_q, acc_d;
  logic                 neg;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    sub_d  = sub_q;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    // top multiplier bit carries negative weight (two's complement)
    neg    = sub_q ^ (cnt_q == CNT_LAST);
    if (cmd_i.start) begin
      a_d    = AW'(a_i);
      b_d    = b_i;
      cnt_d  = '0;
      busy_d = 1'b1;
      sub_d  = cmd_i.sub;
      if (cmd_i.clr) begin
        acc_d = '0;
      end
    end else if (busy_q) begin
      if (b_q[0]) begin
        acc_d = neg ? acc_q - a_q : acc_q + a_q;
      end
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CNT_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sub_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sub_q  <= sub_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign acc_o  = acc_q;

endmodule
`default_nettype wire
